// ===== rtl/svct_pkg.sv =====
// Shared types and constants for the space-vector PWM compare-time block.
// No dependencies; used by svpwm_compare_times_top and the testbench.
package svct_pkg;

    // sqrt(3) in unsigned Q1.16
    localparam logic [16:0] SQRT3_Q16 = 17'd113512;

    // Register indexes on the configuration channel
    localparam logic [1:0] CFG_PWM_PERIOD  = 2'd0;
    localparam logic [1:0] CFG_BUS_VOLTAGE = 2'd1;

    // Reset values of the configuration registers
    localparam logic [15:0] PERIOD_RESET = 16'd10000;
    localparam logic [14:0] VBUS_RESET   = 15'd1000;

    // Divider shapes: ticks from voltage, then over-modulation rescale
    localparam int Q1W = 33;   // quotient bits of the tick conversion
    localparam int Q2W = 16;   // quotient bits of the rescale (never above period)
    localparam int SW  = 34;   // width of T1 + T2

    typedef enum logic [2:0] {
        SEC_ZERO  = 3'd0,
        SEC_1     = 3'd1,
        SEC_2     = 3'd2,
        SEC_3     = 3'd3,
        SEC_4     = 3'd4,
        SEC_5     = 3'd5,
        SEC_6     = 3'd6,
        SEC_SEVEN = 3'd7
    } t_sector;

    typedef struct packed {
        logic signed [15:0] v_alpha;
        logic signed [15:0] v_beta;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  sector_code;
        logic [14:0] compare_a;
        logic [14:0] compare_b;
        logic [14:0] compare_c;
    } t_out_beat;

endpackage

// ===== rtl/svpwm_compare_times_top.sv =====
// Space-vector PWM compare-time generator, fully pipelined.
// Depends on svct_pkg and svct_div.
//
// Usage:
//   Pulse start with an alpha/beta vector on i_in; busy is always low, so a
//   vector may be presented on every clock. Each vector yields exactly one
//   beat on o_res, flagged by o_res_valid for a single cycle. One vector
//   per cycle is sustained.
//   The path runs through two pairs of pipelined dividers: 33 stages to turn the
//   selected voltages into ticks, then 16 stages for the over-modulation
//   rescale, plus projection, sector, multiply, over-modulation test and output stages.
//   The result carries the sector code and the three compare counts.
//   Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; index 0 is the PWM period, index 1 the bus voltage.
//   o_cfg_ready is always high. Change registers only with the pipe empty.
//   Reset (synchronous, active low) empties the pipeline and restores a
//   period of 10000 ticks and a bus voltage of 1000.
//   The receiver cannot stall: results appear once and must be taken.
module svpwm_compare_times_top
    import svct_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_beat  i_in,
    output logic      o_res_valid,
    output t_out_beat o_res,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int SEC_DLY = 1 + Q1W + 1 + Q2W;
    localparam int LAT     = 3 + Q1W + 1 + Q2W + 1;

    logic accept;
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // configuration registers
    logic [15:0] r_pwm_period;
    logic [14:0] r_bus_voltage;
    logic [14:0] vdc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period  <= PERIOD_RESET;
            r_bus_voltage <= VBUS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_PWM_PERIOD) r_pwm_period <= i_cfg_data;
            if (i_cfg_index == CFG_BUS_VOLTAGE) r_bus_voltage <= i_cfg_data[14:0];
        end
    end

    // zero bus voltage counts as one
    assign vdc = (r_bus_voltage == 15'd0) ? 15'd1 : r_bus_voltage;

    // valid bits travel alongside the data
    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[LAT-2:0], accept};
    end

    // stage 1: sqrt3 products and scaled terms
    logic signed [33:0] r_sa, r_sb;
    logic signed [34:0] r_a3, r_b16;
    logic signed [33:0] n_sa, n_sb;
    logic signed [34:0] n_a3, n_b16;

    always_comb begin
        n_sa  = 34'(i_in.v_alpha) * $signed({17'd0, SQRT3_Q16});
        n_sb  = 34'(i_in.v_beta) * $signed({17'd0, SQRT3_Q16});
        n_a3  = (35'(i_in.v_alpha) <<< 17) + (35'(i_in.v_alpha) <<< 16);
        n_b16 = 35'(i_in.v_beta) <<< 16;
    end

    always_ff @(posedge i_clk) begin
        r_sa  <= n_sa;
        r_sb  <= n_sb;
        r_a3  <= n_a3;
        r_b16 <= n_b16;
    end

    // stage 2: sector code, X/Y/Z, pick and clamp the two active terms
    logic signed [36:0] sa, sb, a3, b16, x17, y17, z17, n1, n2;
    logic [2:0]  n_sec;
    logic [33:0] n_u1, n_u2;
    logic [2:0]  r_sec;
    logic [33:0] r_u1, r_u2;

    always_comb begin
        sa  = 37'(r_sa);
        sb  = 37'(r_sb);
        a3  = 37'(r_a3);
        b16 = 37'(r_b16);
        n_sec[0] = (b16 > 37'sd0);
        n_sec[1] = (sa - b16 > 37'sd0);
        n_sec[2] = (-sa - b16 > 37'sd0);
        x17 = sb + sb;
        y17 = a3 + sb;
        z17 = sb - a3;
        case (t_sector'(n_sec))
            SEC_1:   begin n1 = z17;  n2 = y17;  end
            SEC_2:   begin n1 = y17;  n2 = -x17; end
            SEC_3:   begin n1 = -z17; n2 = x17;  end
            SEC_4:   begin n1 = -x17; n2 = z17;  end
            SEC_5:   begin n1 = x17;  n2 = -y17; end
            SEC_6:   begin n1 = -y17; n2 = -z17; end
            default: begin n1 = '0;   n2 = '0;   end
        endcase
        n_u1 = (n1 > 37'sd0) ? n1[33:0] : 34'd0;
        n_u2 = (n2 > 37'sd0) ? n2[33:0] : 34'd0;
    end

    always_ff @(posedge i_clk) begin
        r_sec <= n_sec;
        r_u1  <= n_u1;
        r_u2  <= n_u2;
    end

    // stage 3: scale by period
    logic [49:0] r_p1, r_p2;
    always_ff @(posedge i_clk) begin
        r_p1 <= 50'(r_u1) * 50'(r_pwm_period);
        r_p2 <= 50'(r_u2) * 50'(r_pwm_period);
    end

    // ticks = (num * period / 2^17) / bus voltage
    logic [Q1W-1:0] q1, q2;

    svct_div #(.NW(Q1W), .DW(15), .QW(Q1W)) u_div_t1 (
        .i_clk (i_clk),
        .i_num (r_p1[49:17]),
        .i_den (vdc),
        .o_quo (q1)
    );

    svct_div #(.NW(Q1W), .DW(15), .QW(Q1W)) u_div_t2 (
        .i_clk (i_clk),
        .i_num (r_p2[49:17]),
        .i_den (vdc),
        .o_quo (q2)
    );

    // over-modulation test and rescale numerators
    logic [SW-1:0] r_sum;
    logic          r_ov;
    logic [15:0]   r_q1, r_q2;
    logic [48:0]   r_m1, r_m2;
    logic [SW-1:0] n_sum;

    assign n_sum = SW'(q1) + SW'(q2);

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        r_ov  <= n_sum > SW'(r_pwm_period);
        r_q1  <= q1[15:0];
        r_q2  <= q2[15:0];
        r_m1  <= 49'(q1) * 49'(r_pwm_period);
        r_m2  <= 49'(q2) * 49'(r_pwm_period);
    end

    logic [Q2W-1:0] d1, d2;

    svct_div #(.NW(49), .DW(SW), .QW(Q2W)) u_div_r1 (
        .i_clk (i_clk),
        .i_num (r_m1),
        .i_den (r_sum),
        .o_quo (d1)
    );

    svct_div #(.NW(49), .DW(SW), .QW(Q2W)) u_div_r2 (
        .i_clk (i_clk),
        .i_num (r_m2),
        .i_den (r_sum),
        .o_quo (d2)
    );

    // side data delay lines
    logic [2:0]  r_sec_dl [SEC_DLY];
    logic [15:0] r_q1_dl  [Q2W];
    logic [15:0] r_q2_dl  [Q2W];
    logic        r_ov_dl  [Q2W];

    always_ff @(posedge i_clk) begin
        r_sec_dl[0] <= r_sec;
        for (int k = 1; k < SEC_DLY; k++) r_sec_dl[k] <= r_sec_dl[k-1];
        r_q1_dl[0] <= r_q1;
        r_q2_dl[0] <= r_q2;
        r_ov_dl[0] <= r_ov;
        for (int k = 1; k < Q2W; k++) begin
            r_q1_dl[k] <= r_q1_dl[k-1];
            r_q2_dl[k] <= r_q2_dl[k-1];
            r_ov_dl[k] <= r_ov_dl[k-1];
        end
    end

    // final stage: seven-segment compares in quarter ticks, map by sector
    logic [15:0] t1, t2;
    logic [17:0] ta4, tb4, tc4;
    logic [14:0] ta, tb, tc;
    t_out_beat   n_res;
    t_out_beat   r_res;

    always_comb begin
        t1  = r_ov_dl[Q2W-1] ? d1 : r_q1_dl[Q2W-1];
        t2  = r_ov_dl[Q2W-1] ? d2 : r_q2_dl[Q2W-1];
        ta4 = 18'(r_pwm_period) - 18'(t1) - 18'(t2);
        tb4 = ta4 + {1'b0, t1, 1'b0};
        tc4 = tb4 + {1'b0, t2, 1'b0};
        ta  = ta4[16:2];
        tb  = tb4[16:2];
        tc  = tc4[16:2];
        n_res.sector_code = r_sec_dl[SEC_DLY-1];
        case (t_sector'(r_sec_dl[SEC_DLY-1]))
            SEC_1: begin n_res.compare_a = tb; n_res.compare_b = ta; n_res.compare_c = tc; end
            SEC_2: begin n_res.compare_a = ta; n_res.compare_b = tc; n_res.compare_c = tb; end
            SEC_3: begin n_res.compare_a = ta; n_res.compare_b = tb; n_res.compare_c = tc; end
            SEC_4: begin n_res.compare_a = tc; n_res.compare_b = tb; n_res.compare_c = ta; end
            SEC_5: begin n_res.compare_a = tc; n_res.compare_b = ta; n_res.compare_c = tb; end
            SEC_6: begin n_res.compare_a = tb; n_res.compare_b = tc; n_res.compare_c = ta; end
            default: begin
                // zero vector (and the impossible code seven)
                n_res.sector_code = SEC_ZERO;
                n_res.compare_a   = ta;
                n_res.compare_b   = ta;
                n_res.compare_c   = ta;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res       = r_res;
    assign o_res_valid = r_vld[LAT-1];

endmodule

// ===== rtl/svct_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Stand-alone; instantiated by svpwm_compare_times_top.
module svct_div #(
    parameter int NW = 33,   // numerator width
    parameter int DW = 15,   // divisor width
    parameter int QW = 33    // quotient bits; needs num < den * 2**QW
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_q   [QW];
    logic [DW-1:0] r_den [QW];

    // partial remainder starts with the numerator bits above the quotient
    logic [NW+DW-1:0] wide_num;
    logic [DW-1:0]    rem_init;
    logic [QW-1:0]    q_init;

    assign wide_num = {{DW{1'b0}}, i_num};
    assign rem_init = DW'(wide_num >> QW);
    assign q_init   = QW'(i_num);

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_q;

        if (k == 0) begin : g_first
            assign rem_in = rem_init;
            assign q_in   = q_init;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
            assign den_in = r_den[k-1];
        end

        // shift in next dividend bit, subtract if it fits
        always_comb begin
            trial = {rem_in, q_in[QW-1]};
            ge    = trial >= {1'b0, den_in};
            n_rem = ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
            n_q   = {q_in[QW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_q[k]   <= n_q;
            r_den[k] <= den_in;
        end
    end

    assign o_quo = r_q[QW-1];

endmodule

// ===== sim/tb.sv =====
// Testbench for svpwm_compare_times_top: drives alpha/beta vectors and checks each
// result beat against a predictor of the sector and compare counts.
// Depends on svct_pkg and the RTL of svpwm_compare_times_top.
module tb;
    import svct_pkg::*;

    localparam int LATENCY = 54;

    // Holds expected compare beats and checks results in order
    class compare_board;
        t_out_beat pending[$];
        int        errors;
        logic [15:0] period;
        logic [14:0] vbus;

        function new();
            errors = 0;
            period = PERIOD_RESET;
            vbus   = VBUS_RESET;
        endfunction

        // Active time in ticks from a voltage scaled by 2^17
        function longint unsigned ticks(longint num17);
            longint unsigned vd;
            vd = (vbus == 0) ? 64'd1 : 64'(vbus);
            if (num17 <= 0) return 0;
            return (longint'(num17) * 64'(period)) / (vd << 17);
        endfunction

        function void note_vector(t_in_beat v);
            longint a, b, sa, b16, a3, x17, y17, z17, n1, n2;
            longint unsigned t1, t2, s, ta, tb, tc, p;
            t_sector sec;
            t_out_beat r;
            a = longint'(v.v_alpha);
            b = longint'(v.v_beta);
            p = 64'(period);
            sa = longint'(SQRT3_Q16) * a;
            b16 = b * 65536;
            a3 = a * 3 * 65536;
            sec = t_sector'({(-sa - b16 > 0), (sa - b16 > 0), (b > 0)});
            x17 = 2 * longint'(SQRT3_Q16) * b;
            y17 = a3 + longint'(SQRT3_Q16) * b;
            z17 = -a3 + longint'(SQRT3_Q16) * b;
            case (sec)
                SEC_1: begin n1 = z17;  n2 = y17;  end
                SEC_2: begin n1 = y17;  n2 = -x17; end
                SEC_3: begin n1 = -z17; n2 = x17;  end
                SEC_4: begin n1 = -x17; n2 = z17;  end
                SEC_5: begin n1 = x17;  n2 = -y17; end
                SEC_6: begin n1 = -y17; n2 = -z17; end
                default: begin n1 = 0; n2 = 0; end
            endcase
            t1 = ticks(n1);
            t2 = ticks(n2);
            // over-modulation: rescale with the unscaled sum
            if (t1 + t2 > p) begin
                s = t1 + t2;
                t1 = (t1 * p) / s;
                t2 = (t2 * p) / s;
            end
            ta = p - (t1 + t2);
            tb = ta + 2 * t1;
            tc = tb + 2 * t2;
            ta = ta >> 2;
            tb = tb >> 2;
            tc = tc >> 2;
            r.sector_code = sec;
            case (sec)
                SEC_1: begin r.compare_a = 15'(tb); r.compare_b = 15'(ta); r.compare_c = 15'(tc); end
                SEC_2: begin r.compare_a = 15'(ta); r.compare_b = 15'(tc); r.compare_c = 15'(tb); end
                SEC_3: begin r.compare_a = 15'(ta); r.compare_b = 15'(tb); r.compare_c = 15'(tc); end
                SEC_4: begin r.compare_a = 15'(tc); r.compare_b = 15'(tb); r.compare_c = 15'(ta); end
                SEC_5: begin r.compare_a = 15'(tc); r.compare_b = 15'(ta); r.compare_c = 15'(tb); end
                SEC_6: begin r.compare_a = 15'(tb); r.compare_b = 15'(tc); r.compare_c = 15'(ta); end
                default: begin
                    r.sector_code = SEC_ZERO;
                    r.compare_a = 15'(ta); r.compare_b = 15'(ta); r.compare_c = 15'(ta);
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_beat(t_out_beat got);
            t_out_beat want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.sector_code !== want.sector_code || got.compare_a !== want.compare_a ||
                got.compare_b !== want.compare_b || got.compare_c !== want.compare_c) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: want N=%0d a=%0d b=%0d c=%0d, got N=%0d a=%0d b=%0d c=%0d",
                             want.sector_code, want.compare_a, want.compare_b, want.compare_c,
                             got.sector_code, got.compare_a, got.compare_b, got.compare_c);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_beat    i_in;
    logic        o_res_valid;
    t_out_beat   o_res;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    compare_board board;
    int idle_pct;

    svpwm_compare_times_top dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: sample at the edge that ends the strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) board.check_beat(o_res);
    end

    // Present one vector, with optional idle cycles ahead of it
    task automatic send_vector(logic signed [15:0] va, logic signed [15:0] vb);
        t_in_beat v;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        v.v_alpha = va;
        v.v_beta  = vb;
        start <= 1'b1;
        i_in  <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_vector(v);
    endtask

    // Let the pipe run dry, then allow the latency to pass
    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_PWM_PERIOD) board.period = val;
        else board.vbus = val[14:0];
        @(posedge i_clk);
    endtask

    // Random vector: mostly moderate magnitudes, some full-range
    task automatic random_vector();
        logic signed [15:0] va, vb;
        if ($urandom_range(3) == 0) begin
            va = 16'($urandom);
            vb = 16'($urandom);
        end else begin
            va = $signed(16'($urandom_range(4000))) - 16'sd2000;
            vb = $signed(16'($urandom_range(4000))) - 16'sd2000;
        end
        send_vector(va, vb);
    endtask

    initial begin
        logic [15:0] periods [4];
        logic [15:0] buses   [4];
        board = new();
        start = 0; i_in = '0; i_cfg_valid = 0; i_cfg_index = CFG_PWM_PERIOD; i_cfg_data = '0;
        idle_pct = 0;
        i_rst_n = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, extremes, zero vector, every sector
        send_vector(0, 0);
        send_vector(16'sh7FFF, 0);
        send_vector(16'sh8000, 0);
        send_vector(0, 16'sh7FFF);
        send_vector(0, 16'sh8000);
        send_vector(16'sh7FFF, 16'sh7FFF);
        send_vector(16'sh8000, 16'sh8000);
        send_vector(16'sh7FFF, 16'sh8000);
        send_vector(16'sh8000, 16'sh7FFF);
        send_vector(300, 100);
        send_vector(0, 300);
        send_vector(-300, 100);
        send_vector(-300, -100);
        send_vector(0, -300);
        send_vector(300, -100);
        // sector edges where rounding can go negative
        send_vector(1000, 1732);
        send_vector(-1000, 1732);
        send_vector(1, 0);
        send_vector(-1, 0);
        send_vector(0, 1);
        send_vector(0, -1);
        drain();

        // zero period and zero bus voltage
        write_reg(CFG_PWM_PERIOD, 0);
        write_reg(CFG_BUS_VOLTAGE, 0);
        send_vector(500, 200);
        send_vector(0, 0);
        drain();

        periods = '{16'd1, 16'd65535, 16'd3333, 16'd10000};
        buses   = '{16'd32767, 16'd1, 16'd700, 16'd1000};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_PWM_PERIOD, periods[ph]);
            write_reg(CFG_BUS_VOLTAGE, buses[ph]);
            for (int k = 0; k < 4; k++) begin
                idle_pct = (k == 0) ? 0 : (k == 1) ? 83 : (k == 2) ? 31 : 0;
                for (int j = 0; j < 65; j++) random_vector();
                if (k == 1) begin
                    // hold off until every result is in
                    start <= 1'b0;
                    while (board.pending.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end
        idle_pct = 0;

        start <= 1'b0;
        fork
            while (board.pending.size() != 0) @(posedge i_clk);
        join
        repeat (LATENCY + 10) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== svpwm_compare_times_top.f =====
rtl/svct_pkg.sv
rtl/svct_div.sv
rtl/svpwm_compare_times_top.sv
sim/tb.sv
